/* rtl/dhfk_pkg.sv */
// Shared types, constants and fixed-point helpers for the DH chain forward kinematics block.
// No dependencies.
package dhfk_pkg;

  localparam int JOINT_COUNT  = 7;
  localparam int ANGLE_W      = 16;
  localparam int ROT_W        = 16;
  localparam int POS_W        = 20;
  localparam int ACC_W        = 21;
  localparam int OFS_W        = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CX_W         = 34;
  localparam int CZ_W         = 20;
  localparam int SC_LAT       = CORDIC_STEPS + 2;

  localparam logic signed [ANGLE_W:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [ANGLE_W:0] PI_Q13      = 17'sd25736;
  localparam logic signed [CX_W-1:0]  GAIN_Q30    = 34'sd652032874;
  localparam logic signed [ROT_W-1:0] ONE_Q14     = 16'sd16384;

  typedef enum logic [1:0] {
    CFG_MIRROR  = 2'd0,
    CFG_UPPER   = 2'd1,
    CFG_FOREARM = 2'd2,
    CFG_WRIST   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TW_PLUS,
    TW_MINUS,
    TW_ZERO
  } twist_t;

  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    rot_t [8:0] rot;  // row-major
    acc_t [2:0] pos;
  } chain_t;

  typedef struct packed {
    rot_t [JOINT_COUNT-1:0] s;
    rot_t [JOINT_COUNT-1:0] c;
  } sc_t;

  function automatic logic signed [CZ_W-1:0] atan_at(input logic [3:0] i);
    logic signed [CZ_W-1:0] r;
    case (i)
      4'd0:    r = 20'sd51472;
      4'd1:    r = 20'sd30386;
      4'd2:    r = 20'sd16055;
      4'd3:    r = 20'sd8150;
      4'd4:    r = 20'sd4091;
      4'd5:    r = 20'sd2047;
      4'd6:    r = 20'sd1024;
      4'd7:    r = 20'sd512;
      4'd8:    r = 20'sd256;
      4'd9:    r = 20'sd128;
      4'd10:   r = 20'sd64;
      4'd11:   r = 20'sd32;
      4'd12:   r = 20'sd16;
      4'd13:   r = 20'sd8;
      4'd14:   r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

  // floor((v + 2^13) / 2^14), clamped to +-1.0
  function automatic rot_t round_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    rot_t r;
    t = (v + 34'sd8192) >>> 14;
    if (t > 34'sd16384)       r = ONE_Q14;
    else if (t < -34'sd16384) r = -ONE_Q14;
    else                      r = t[ROT_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/dh_chain_forward_kinematics.sv */
// Top level of the seven-joint DH forward kinematics pipeline.
// Depends on dhfk_pkg, dhfk_sincos_lane and dhfk_link_stage.
//
// Usage:
//   Input channel: one beat carries all seven joint angles (Q3.13 rad).
//   Output channel: one beat per input beat with the 3x3 rotation (Q1.14)
//   and the saturated position (2^-16 m).
//   Seven sine/cosine lanes run side by side, one per joint; each is an
//   18-deep pipeline (fold, 16 CORDIC steps, round). A chain of seven link
//   stages then merges the lane results into the pose, one joint per stage.
//   Path from input beat to output beat: the 18 lane stages, the 7 link
//   stages and the output register.
//   Throughput: one beat per cycle when not stalled; each link stage holds
//   one level of multiplies plus round and clamp, which sets the clock.
//   Stall: when a result sits in the output register and out_stall is high,
//   the whole pipeline freezes and in_stall rises; otherwise every cycle
//   moves, so a waiting result never blocks new beats from entering
//   while the register is free.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the register
//   defaults. The user must write configuration only while idle; the block has no check for it.
module dh_chain_forward_kinematics (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] in_joint_angle_1,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] in_joint_angle_2,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] in_joint_angle_3,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] in_joint_angle_4,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] in_joint_angle_5,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] in_joint_angle_6,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] in_joint_angle_7,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_00,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_01,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_02,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_10,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_11,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_12,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_20,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_21,
  output logic signed [dhfk_pkg::ROT_W-1:0]   out_rot_22,
  output logic signed [dhfk_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [dhfk_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [dhfk_pkg::POS_W-1:0]   out_pos_z
);

  localparam int JN = dhfk_pkg::JOINT_COUNT;

  // configuration registers
  logic                       mirror_r;
  logic [dhfk_pkg::OFS_W-1:0] upper_r, fore_r, wrist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
      upper_r  <= 16'd19661;
      fore_r   <= 16'd16384;
      wrist_r  <= 16'd5243;
    end else if (cfg_we) begin
      unique case (dhfk_pkg::cfg_idx_t'(cfg_index))
        dhfk_pkg::CFG_MIRROR:  mirror_r <= cfg_data[0];
        dhfk_pkg::CFG_UPPER:   upper_r  <= cfg_data;
        dhfk_pkg::CFG_FOREARM: fore_r   <= cfg_data;
        dhfk_pkg::CFG_WRIST:   wrist_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: freeze only when a held result is being stalled
  logic out_valid_r;
  logic en;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // sine/cosine lanes
  logic signed [dhfk_pkg::ANGLE_W-1:0] ang [JN];
  dhfk_pkg::sc_t                       sc0;
  logic [dhfk_pkg::SC_LAT-1:0]         vsh_r;

  assign ang[0] = in_joint_angle_1;
  assign ang[1] = in_joint_angle_2;
  assign ang[2] = in_joint_angle_3;
  assign ang[3] = in_joint_angle_4;
  assign ang[4] = in_joint_angle_5;
  assign ang[5] = in_joint_angle_6;
  assign ang[6] = in_joint_angle_7;

  for (genvar j = 0; j < JN; j++) begin : g_lane
    dhfk_sincos_lane u_lane (
      .clk   (clk),
      .en    (en),
      .angle (ang[j]),
      .sin_q (sc0.s[j]),
      .cos_q (sc0.c[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsh_r <= '0;
    end else if (en) begin
      vsh_r <= {vsh_r[dhfk_pkg::SC_LAT-2:0], in_valid};
    end
  end

  // link chain, seeded with identity rotation and zero position
  logic             v [JN+1];
  dhfk_pkg::chain_t ch [JN+1];
  dhfk_pkg::sc_t    sc [JN+1];

  always_comb begin
    ch[0] = '0;
    ch[0].rot[0] = dhfk_pkg::ONE_Q14;
    ch[0].rot[4] = dhfk_pkg::ONE_Q14;
    ch[0].rot[8] = dhfk_pkg::ONE_Q14;
  end
  assign v[0]  = vsh_r[dhfk_pkg::SC_LAT-1];
  assign sc[0] = sc0;

  for (genvar j = 0; j < JN; j++) begin : g_link
    logic [dhfk_pkg::OFS_W-1:0] d;
    dhfk_pkg::twist_t           tw;
    always_comb begin
      if (j == 2)      d = upper_r;
      else if (j == 4) d = fore_r;
      else if (j == 6) d = wrist_r;
      else             d = '0;
      if (j == 6)                          tw = dhfk_pkg::TW_ZERO;
      else if (((j % 2) == 1) ^ mirror_r)  tw = dhfk_pkg::TW_MINUS;
      else                                 tw = dhfk_pkg::TW_PLUS;
    end
    dhfk_link_stage u_link (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (v[j]),
      .chain_in  (ch[j]),
      .sc_in     (sc[j]),
      .s         (sc[j].s[j]),
      .c         (sc[j].c[j]),
      .d         (d),
      .tw        (tw),
      .valid_out (v[j+1]),
      .chain_out (ch[j+1]),
      .sc_out    (sc[j+1])
    );
  end

  // output register with position saturation
  dhfk_pkg::rot_t                    rot_r [9];
  logic signed [dhfk_pkg::POS_W-1:0] pos_r [3];
  logic signed [dhfk_pkg::POS_W-1:0] pos_sat [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (ch[JN].pos[r] > 21'sd524287)       pos_sat[r] = 20'sd524287;
      else if (ch[JN].pos[r] < -21'sd524288) pos_sat[r] = -20'sd524287 - 20'sd1;
      else pos_sat[r] = ch[JN].pos[r][dhfk_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v[JN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) rot_r[k] <= ch[JN].rot[k];
      for (int r = 0; r < 3; r++) pos_r[r] <= pos_sat[r];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rot_00 = rot_r[0];
  assign out_rot_01 = rot_r[1];
  assign out_rot_02 = rot_r[2];
  assign out_rot_10 = rot_r[3];
  assign out_rot_11 = rot_r[4];
  assign out_rot_12 = rot_r[5];
  assign out_rot_20 = rot_r[6];
  assign out_rot_21 = rot_r[7];
  assign out_rot_22 = rot_r[8];
  assign out_pos_x  = pos_r[0];
  assign out_pos_y  = pos_r[1];
  assign out_pos_z  = pos_r[2];

endmodule

/* rtl/dhfk_sincos_lane.sv */
// One sine/cosine lane: quadrant fold, 16 pipelined CORDIC steps, round and clamp.
// Depends on dhfk_pkg.
module dhfk_sincos_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0] angle,
  output dhfk_pkg::rot_t                      sin_q,
  output dhfk_pkg::rot_t                      cos_q
);

  localparam int N = dhfk_pkg::CORDIC_STEPS;

  logic signed [dhfk_pkg::CX_W-1:0] x_r [0:N];
  logic signed [dhfk_pkg::CX_W-1:0] y_r [0:N];
  logic signed [dhfk_pkg::CZ_W-1:0] z_r [0:N];
  logic                             f_r [0:N];
  dhfk_pkg::rot_t                   s_r, c_r;

  logic signed [dhfk_pkg::ANGLE_W:0] a_ext, a_fold;
  logic                              flip;
  logic signed [dhfk_pkg::CX_W-1:0]  xs, ys;
  logic signed [17:0]                xq, yq;
  dhfk_pkg::rot_t                    xc, yc;

  always_comb begin
    a_ext  = {angle[dhfk_pkg::ANGLE_W-1], angle};
    a_fold = a_ext;
    flip   = 1'b0;
    if (a_ext > dhfk_pkg::HALF_PI_Q13) begin
      a_fold = a_ext - dhfk_pkg::PI_Q13;
      flip   = 1'b1;
    end else if (a_ext < -dhfk_pkg::HALF_PI_Q13) begin
      a_fold = a_ext + dhfk_pkg::PI_Q13;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= dhfk_pkg::GAIN_Q30;
      y_r[0] <= '0;
      // angle * 8: 17-bit folded angle plus three zero bits fills CZ_W
      z_r[0] <= {a_fold, 3'b000};
      f_r[0] <= flip;
      for (int i = 0; i < N; i++) begin
        if (!z_r[i][dhfk_pkg::CZ_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - dhfk_pkg::atan_at(4'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + dhfk_pkg::atan_at(4'(i));
        end
        f_r[i+1] <= f_r[i];
      end
      s_r <= f_r[N] ? -yc : yc;
      c_r <= f_r[N] ? -xc : xc;
    end
  end

  always_comb begin
    xs = x_r[N] + 34'sd32768;
    ys = y_r[N] + 34'sd32768;
    xq = xs[dhfk_pkg::CX_W-1:16];
    yq = ys[dhfk_pkg::CX_W-1:16];
    if (xq > 18'sd16384)       xc = dhfk_pkg::ONE_Q14;
    else if (xq < -18'sd16384) xc = -dhfk_pkg::ONE_Q14;
    else                       xc = xq[dhfk_pkg::ROT_W-1:0];
    if (yq > 18'sd16384)       yc = dhfk_pkg::ONE_Q14;
    else if (yq < -18'sd16384) yc = -dhfk_pkg::ONE_Q14;
    else                       yc = yq[dhfk_pkg::ROT_W-1:0];
  end

  assign sin_q = s_r;
  assign cos_q = c_r;

endmodule

/* rtl/dhfk_link_stage.sv */
// One chain stage: multiplies the running pose by one DH link transform.
// Depends on dhfk_pkg.
module dhfk_link_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  dhfk_pkg::chain_t              chain_in,
  input  dhfk_pkg::sc_t                 sc_in,
  input  dhfk_pkg::rot_t                s,
  input  dhfk_pkg::rot_t                c,
  input  logic [dhfk_pkg::OFS_W-1:0]    d,
  input  dhfk_pkg::twist_t              tw,
  output logic                          valid_out,
  output dhfk_pkg::chain_t              chain_out,
  output dhfk_pkg::sc_t                 sc_out
);

  logic             valid_r;
  dhfk_pkg::chain_t chain_r, chain_nxt;
  dhfk_pkg::sc_t    sc_r;

  always_comb begin
    logic signed [33:0] sum0, m, neg_m, pd;
    dhfk_pkg::rot_t     o0, o1, o2;
    chain_nxt = chain_in;
    for (int r = 0; r < 3; r++) begin
      o0    = chain_in.rot[3*r];
      o1    = chain_in.rot[3*r+1];
      o2    = chain_in.rot[3*r+2];
      sum0  = 34'(c * o0) + 34'(s * o1);
      m     = 34'(s * o0) - 34'(c * o1);
      neg_m = -m;
      pd    = (34'($signed({1'b0, d}) * o2) + 34'sd8192) >>> 14;
      chain_nxt.pos[r] = chain_in.pos[r] + pd[dhfk_pkg::ACC_W-1:0];
      chain_nxt.rot[3*r] = dhfk_pkg::round_q14(sum0);
      case (tw)
        dhfk_pkg::TW_PLUS: begin
          chain_nxt.rot[3*r+1] = o2;
          chain_nxt.rot[3*r+2] = dhfk_pkg::round_q14(m);
        end
        dhfk_pkg::TW_MINUS: begin
          chain_nxt.rot[3*r+1] = -o2;
          chain_nxt.rot[3*r+2] = dhfk_pkg::round_q14(neg_m);
        end
        default: begin
          chain_nxt.rot[3*r+1] = dhfk_pkg::round_q14(neg_m);
          chain_nxt.rot[3*r+2] = o2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_r <= chain_nxt;
      sc_r    <= sc_in;
    end
  end

  assign valid_out = valid_r;
  assign chain_out = chain_r;
  assign sc_out    = sc_r;

endmodule
